// ----- hw/rtl/scef_pkg.sv -----
package scef_pkg;

    // command opcodes as they arrive on the input
    typedef enum logic [2:0] {
        OP_SET_TARGET = 3'd0,
        OP_SET_SPEED  = 3'd1,
        OP_SET_ACCEL  = 3'd2,
        OP_GET_POS    = 3'd3,
        OP_GET_MOVING = 3'd4,
        OP_GET_ERRORS = 3'd5,
        OP_GO_HOME    = 3'd6
    } t_op;

    // command bytes on the wire
    localparam logic [7:0] CMD_SET_TARGET = 8'h84;
    localparam logic [7:0] CMD_SET_SPEED  = 8'h87;
    localparam logic [7:0] CMD_SET_ACCEL  = 8'h89;
    localparam logic [7:0] CMD_GET_POS    = 8'h90;
    localparam logic [7:0] CMD_GET_MOVING = 8'h93;
    localparam logic [7:0] CMD_GET_ERRORS = 8'hA1;
    localparam logic [7:0] CMD_GO_HOME    = 8'hA2;

    // crc-7, reflected polynomial
    localparam logic [7:0] CRC7_POLY = 8'h91;

    // descriptor queue between front and back
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    // frame byte positions
    localparam logic [2:0] POS_CMD     = 3'd0;
    localparam logic [2:0] POS_CHANNEL = 3'd1;
    localparam logic [2:0] POS_LOW     = 3'd2;
    localparam logic [2:0] POS_HIGH    = 3'd3;

    // one classified command, ready to be serialized
    typedef struct packed {
        logic [7:0] cmd_byte;
        logic [6:0] channel;
        logic [6:0] data_low;
        logic [6:0] data_high;
        logic [2:0] n_data;   // command bytes in the frame: 1, 2 or 4
        logic       crc_en;   // append a crc byte after the command bytes
    } t_frame_desc;

    // one crc-7 byte update, lsb first
    function automatic logic [7:0] crc7_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = c ^ CRC7_POLY;
            end
            c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/scef_front.sv -----
module scef_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           i_op,
    input  logic [6:0]           i_channel,
    input  logic [11:0]          i_value,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output scef_pkg::t_frame_desc o_q_desc
);
    import scef_pkg::*;

    logic r_crc_enable;
    logic op_ok;

    // crc enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_enable <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_crc_enable <= i_cfg_wr_data;
        end
    end

    // classify the command: command byte and frame length
    // operands: value times four split into two 7-bit bytes
    always_comb begin
        op_ok              = 1'b1;
        o_q_desc.cmd_byte  = CMD_GO_HOME;
        o_q_desc.n_data    = 3'd1;
        o_q_desc.channel   = i_channel;
        o_q_desc.data_low  = {i_value[4:0], 2'b00};
        o_q_desc.data_high = i_value[11:5];
        o_q_desc.crc_en    = r_crc_enable;
        unique case (i_op)
            OP_SET_TARGET: begin
                o_q_desc.cmd_byte = CMD_SET_TARGET;
                o_q_desc.n_data   = 3'd4;
            end
            OP_SET_SPEED: begin
                o_q_desc.cmd_byte = CMD_SET_SPEED;
                o_q_desc.n_data   = 3'd4;
            end
            OP_SET_ACCEL: begin
                o_q_desc.cmd_byte = CMD_SET_ACCEL;
                o_q_desc.n_data   = 3'd4;
            end
            OP_GET_POS: begin
                o_q_desc.cmd_byte = CMD_GET_POS;
                o_q_desc.n_data   = 3'd2;
            end
            OP_GET_MOVING: begin
                o_q_desc.cmd_byte = CMD_GET_MOVING;
            end
            OP_GET_ERRORS: begin
                o_q_desc.cmd_byte = CMD_GET_ERRORS;
            end
            OP_GO_HOME: begin
                o_q_desc.cmd_byte = CMD_GO_HOME;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    // undefined op is taken and dropped
    assign full   = i_q_full;
    assign o_q_wr = push && !i_q_full && op_ok;

endmodule

// ----- hw/rtl/scef_queue.sv -----
module scef_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  scef_pkg::t_frame_desc i_wr_desc,
    input  logic                  i_rd,
    output scef_pkg::t_frame_desc o_rd_desc,
    output logic                  o_full,
    output logic                  o_empty
);
    import scef_pkg::*;

    t_frame_desc          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 wr_en;
    logic                 rd_en;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    assign o_rd_desc = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/scef_back.sv -----
module scef_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  scef_pkg::t_frame_desc i_q_desc,
    output logic                  o_q_rd,
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_frame_byte,
    output logic                  o_last
);
    import scef_pkg::*;

    logic [2:0] r_pos;
    logic [7:0] r_crc;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       advance;
    logic [2:0] total;
    logic       is_last;
    logic [7:0] cur_byte;
    logic [7:0] crc_base;
    logic [7:0] n_crc;

    // move a byte to the output register when it is free or being popped
    assign advance = !i_q_empty && (!r_out_valid || pop);
    assign total   = i_q_desc.n_data + {2'b00, i_q_desc.crc_en};
    assign is_last = (r_pos == total - 3'd1);

    // select the byte at the current position
    always_comb begin
        priority if (i_q_desc.crc_en && r_pos == i_q_desc.n_data) begin
            cur_byte = r_crc;
        end else if (r_pos == POS_CMD) begin
            cur_byte = i_q_desc.cmd_byte;
        end else if (r_pos == POS_CHANNEL) begin
            cur_byte = {1'b0, i_q_desc.channel};
        end else if (r_pos == POS_LOW) begin
            cur_byte = {1'b0, i_q_desc.data_low};
        end else begin
            cur_byte = {1'b0, i_q_desc.data_high};
        end
    end

    // running crc, restarted on each frame
    assign crc_base = (r_pos == POS_CMD) ? 8'h00 : r_crc;
    assign n_crc    = crc7_update(crc_base, cur_byte);

    // byte position and crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_CMD;
        end else if (advance) begin
            r_pos <= is_last ? POS_CMD : r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_crc <= n_crc;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= cur_byte;
            r_out_last <= is_last;
        end
    end

    assign o_q_rd       = advance && is_last;
    assign empty        = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last       = r_out_last;

endmodule

// ----- hw/rtl/servo_command_frame_encoder_unit.sv -----
// channel   | direction | handshake    | beat
// command   | in        | push / full  | op, channel, value
// frame     | out       | pop / empty  | frame_byte, last
// config    | in        | i_cfg_wr_en  | crc_enable
//
// a command is classified combinationally and lands in the queue at its beat; the
// back then sends one frame byte per cycle while its output is free or being popped
// a two-deep descriptor queue lets commands land while a frame is still going out;
// full rises while it holds two commands, and a pop held low stalls the back
// the first byte passes the queue and then the output register before it shows
// synchronous active-low reset empties the queue and output and clears crc_enable
module servo_command_frame_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_op,
    input  logic [6:0]  i_channel,
    input  logic [11:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_last,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);
    import scef_pkg::*;

    logic        q_wr;
    logic        q_rd;
    logic        q_full;
    logic        q_empty;
    t_frame_desc q_wr_desc;
    t_frame_desc q_rd_desc;

    // front: accept and classify
    scef_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_op          (i_op),
        .i_channel     (i_channel),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_desc      (q_wr_desc)
    );

    // descriptor queue
    scef_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_desc (q_wr_desc),
        .i_rd      (q_rd),
        .o_rd_desc (q_rd_desc),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    // back: serialize, appending crc when enabled
    scef_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_desc     (q_rd_desc),
        .o_q_rd       (q_rd),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule
